@@ rtl/core/reservation_station_oldest_ready_unit_macros.svh @@
// assertion macros for the reservation station
// used by the top level only
`ifndef RESERVATION_STATION_OLDEST_READY_UNIT_MACROS_SVH
`define RESERVATION_STATION_OLDEST_READY_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define RS_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define RS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

@@ rtl/core/rsor_pkg.sv @@
// package for the reservation station: sizes, op codes, slot and payload types
// no dependencies
package rsor_pkg;
	localparam int EntryCount = 8;
	localparam int IdxW = (EntryCount > 1) ? $clog2(EntryCount) : 1;
	localparam int AgeW = 16;
	localparam logic [AgeW-1:0] AgeMax = '1;

	localparam logic [1:0] OP_ISSUE    = 2'd0;
	localparam logic [1:0] OP_DISPATCH = 2'd1;
	localparam logic [1:0] OP_RESULT   = 2'd2;
	localparam logic [1:0] OP_TICK     = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic [7:0]         instr_opcode;
		logic signed [31:0] src1;
		logic               src1_ready;
		logic signed [31:0] src2;
		logic               src2_ready;
		logic signed [31:0] src3;
		logic               src3_ready;
		logic [5:0]         dest;
		logic               write_en;
		logic [5:0]         result_tag;
		logic signed [31:0] result_value;
	} in_item_t;

	typedef struct packed {
		logic               dispatched;
		logic [7:0]         out_opcode;
		logic signed [31:0] out_src1;
		logic signed [31:0] out_src2;
		logic signed [31:0] out_src3;
		logic               out_src3_ready;
		logic [5:0]         out_dest;
		logic               out_write_en;
		logic               issue_dropped;
		logic               full_res;
	} out_item_t;

	// contents of one slot
	typedef struct packed {
		logic [7:0]  opcode;
		logic [31:0] opnd1;
		logic        rdy1;
		logic [31:0] opnd2;
		logic        rdy2;
		logic [31:0] opnd3;
		logic        rdy3;
		logic [5:0]  dest;
		logic        wen;
		logic [AgeW-1:0] age;
	} slot_t;

	// oldest-ready candidate handed along the chain
	typedef struct packed {
		logic            found;
		logic [IdxW-1:0] idx;
		logic [AgeW-1:0] age;
	} cand_t;

	// per-cycle command from the control to every cell
	typedef struct packed {
		logic        issue;
		logic        grant_en;
		logic [IdxW-1:0] grant_idx;
		logic        wake;
		logic        tick;
		logic [5:0]  tag;
		logic [31:0] value;
	} cmd_t;
endpackage

@@ rtl/core/rsor_if.sv @@
// valid/ready channel interface carrying one payload
// depends on rsor_pkg through its type parameter default
interface rsor_if #(parameter type payload_t = rsor_pkg::in_item_t) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/rsor_cell.sv @@
// one slot of the station: holds an entry, wakes operands, ages, and
// compares its own readiness against the candidate from its neighbor
// depends on rsor_pkg
module rsor_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rsor_pkg::IdxW-1:0]   my_idx,
	input  rsor_pkg::cmd_t              cmd,
	input  logic                        free_in,
	output logic                        free_out,
	input  rsor_pkg::in_item_t          item,
	input  rsor_pkg::cand_t             cand_in,
	output rsor_pkg::cand_t             cand_out,
	output logic                        busy,
	output rsor_pkg::slot_t             slot
);
	logic busy_q;
	rsor_pkg::slot_t slot_q;
	logic take, ready_here, w1, w2;

	// free_in high means a lower slot already claimed the issue
	assign take = cmd.issue && !busy_q && !free_in;
	assign free_out = free_in || !busy_q;
	assign ready_here = busy_q && slot_q.rdy1 && slot_q.rdy2;
	assign w1 = cmd.wake && !slot_q.rdy1 && (slot_q.opnd1 == {26'd0, cmd.tag});
	assign w2 = cmd.wake && !slot_q.rdy2 && (slot_q.opnd2 == {26'd0, cmd.tag});

	always_comb begin
		cand_out = cand_in;
		if (ready_here && (!cand_in.found || slot_q.age > cand_in.age)) begin
			cand_out.found = 1'b1;
			cand_out.idx = my_idx;
			cand_out.age = slot_q.age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take) begin
			busy_q <= 1'b1;
		end else if (cmd.grant_en && cmd.grant_idx == my_idx) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			slot_q.opcode <= item.instr_opcode;
			slot_q.opnd1 <= item.src1;
			slot_q.rdy1 <= item.src1_ready;
			slot_q.opnd2 <= item.src2;
			slot_q.rdy2 <= item.src2_ready;
			slot_q.opnd3 <= item.src3;
			slot_q.rdy3 <= item.src3_ready;
			slot_q.dest <= item.dest;
			slot_q.wen <= item.write_en;
			slot_q.age <= '0;
		end else if (busy_q) begin
			if (w1) begin
				slot_q.opnd1 <= cmd.value;
				slot_q.rdy1 <= 1'b1;
			end
			if (w2) begin
				slot_q.opnd2 <= cmd.value;
				slot_q.rdy2 <= 1'b1;
			end
			if (cmd.tick && slot_q.age != rsor_pkg::AgeMax) begin
				slot_q.age <= slot_q.age + 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign slot = slot_q;
endmodule

@@ rtl/core/reservation_station_oldest_ready_unit.sv @@
// a result is registered in the output register when its item transfers
// throughput: one item per cycle while the output is not stalled; the oldest-ready
// search is a combinational pass along the chain of N cells, one compare per cell
// reset clears every busy bit and the output valid; slot payload is not reset
// an output register parts the sides: input is taken whenever it is empty or drained
`include "reservation_station_oldest_ready_unit_macros.svh"
module reservation_station_oldest_ready_unit (
	input logic clk,
	input logic arst_n,
	rsor_if.sink   in_ch,
	rsor_if.source out_ch
);
	localparam int N = rsor_pkg::EntryCount;
	rsor_pkg::in_item_t item;
	rsor_pkg::cmd_t cmd;
	rsor_pkg::cand_t cand [N+1];
	logic free_c [N+1];
	logic [N-1:0] busy;
	rsor_pkg::slot_t slots [N];
	rsor_pkg::out_item_t res, res_q;
	logic out_valid_q, fire, full_now, is_issue, is_disp;

	assign item = in_ch.data;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign fire = in_ch.valid && in_ch.ready;
	assign is_issue = fire && item.op == rsor_pkg::OP_ISSUE;
	assign is_disp = fire && item.op == rsor_pkg::OP_DISPATCH;

	assign cand[0] = '0;
	assign free_c[0] = 1'b0;

	always_comb begin
		cmd.issue = is_issue;
		cmd.grant_en = is_disp && cand[N].found;
		cmd.grant_idx = cand[N].idx;
		cmd.wake = fire && item.op == rsor_pkg::OP_RESULT;
		cmd.tick = fire && item.op == rsor_pkg::OP_TICK;
		cmd.tag = item.result_tag;
		cmd.value = item.result_value;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		rsor_cell u_cell (
			.clk(clk), .arst_n(arst_n), .my_idx(rsor_pkg::IdxW'(i)), .cmd(cmd),
			.free_in(free_c[i]), .free_out(free_c[i+1]), .item(item),
			.cand_in(cand[i]), .cand_out(cand[i+1]), .busy(busy[i]), .slot(slots[i])
		);
	end

	// full after this step: issue fills at most one slot
	always_comb begin
		full_now = 1'b0;
		if (is_issue) begin
			full_now = ($countones(busy) >= N - 1);
		end else if (cmd.grant_en) begin
			full_now = 1'b0;
		end else begin
			full_now = &busy;
		end
	end

	always_comb begin
		res = '0;
		if (cmd.grant_en) begin
			res.dispatched = 1'b1;
			res.out_opcode = slots[cand[N].idx].opcode;
			res.out_src1 = slots[cand[N].idx].opnd1;
			res.out_src2 = slots[cand[N].idx].opnd2;
			res.out_src3 = slots[cand[N].idx].opnd3;
			res.out_src3_ready = slots[cand[N].idx].rdy3;
			res.out_dest = slots[cand[N].idx].dest;
			res.out_write_en = slots[cand[N].idx].wen;
		end
		res.issue_dropped = is_issue && !free_c[N];
		res.full_res = full_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			out_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) res_q <= res;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = res_q;

	`RS_ASSERT_IMP(a_drop_full, clk, arst_n, is_issue && !free_c[N], &busy)
	`RS_ASSERT_IMP(a_grant_busy, clk, arst_n, cmd.grant_en, busy[cmd.grant_idx])
	`RS_ASSERT_NEXT(a_out_after_fire, clk, arst_n, fire, out_valid_q)
	`RS_ASSERT_NEXT(a_full_match, clk, arst_n, fire, res_q.full_res == (&busy))
endmodule
